// ===== rtl/cpba_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_pkg
// Shared types and constants for the first-fit page bitmap allocator:
// payload structs, status codes and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cpba_pkg;

  // Field widths
  localparam int ADDR_W = 48;
  localparam int SIZE_W = 32;
  localparam int STAT_W = 2;

  // Default pool size in pages
  localparam int POOL_PAGES_DEF = 1024;

  // Page size (power of two) and derived shift
  localparam int PAGE_BYTES = 4096;
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);

  // Width of a rounded-up page count and of a page offset from the base
  localparam int CNT_W   = SIZE_W - PAGE_SHIFT + 1;
  localparam int FIRST_W = ADDR_W - PAGE_SHIFT;

  // Bitmap word width
  localparam int WORD_W = 32;

  // Operation codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // Result status codes
  localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
  localparam logic [STAT_W-1:0] ST_CHECK   = 2'd1;
  localparam logic [STAT_W-1:0] ST_NOSPACE = 2'd2;

  typedef struct packed {
    logic              func;
    logic [SIZE_W-1:0] byte_size;
    logic [ADDR_W-1:0] free_address;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] run_address;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic clr_step;
    logic load;
    logic calc;
    logic decide;
    logic scan_step;
    logic prep;
    logic mark_step;
    logic resp;
  } cpba_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic reject;
    logic is_free;
    logic found;
    logic scan_last;
    logic mark_last;
  } cpba_sts_t;

endpackage

// ===== rtl/cpba_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_ram
// Generic simple dual-port RAM: one write port, one read port, registered
// read data.
// ----------------------------------------------------------------------------
module cpba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/cpba_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_ctrl
// Controller: sequences bitmap clearing, request checks, first-fit scan,
// run marking and result transfer; drives the handshakes.
// ----------------------------------------------------------------------------
module cpba_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  input  cpba_pkg::cpba_sts_t sts,
  output cpba_pkg::cpba_cmd_t cmd
);

  typedef enum logic [2:0] {
    S_CLR,
    S_IDLE,
    S_CALC,
    S_DECIDE,
    S_SCAN,
    S_PREP,
    S_MARK,
    S_RESP
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // Next state and commands
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r;
    cmd           = '0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CALC;
        end
      end
      S_CALC: begin
        cmd.calc  = 1'b1;
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        cmd.decide = 1'b1;
        if (sts.reject) begin
          state_nxt = S_RESP;
        end else if (sts.is_free) begin
          state_nxt = S_PREP;
        end else begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.found) begin
          state_nxt = S_PREP;
        end else if (sts.scan_last) begin
          state_nxt = S_RESP;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = S_MARK;
      end
      S_MARK: begin
        cmd.mark_step = 1'b1;
        if (sts.mark_last) begin
          state_nxt = S_RESP;
        end
      end
      S_RESP: begin
        // Load the output slot once it is empty or being drained
        if (!out_valid_r || out_ready) begin
          cmd.resp      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLR;
      end
    endcase
  end

  // Hold state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/cpba_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpba_dp
// Datapath: window base register, request checks, byte-serial first-fit
// scan of the page bitmap and word-by-word read-modify-write of a run.
// ----------------------------------------------------------------------------
module cpba_dp #(
  parameter int POOL_PAGES = cpba_pkg::POOL_PAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cpba_pkg::ADDR_W-1:0]   cfg_wdata,
  input  cpba_pkg::in_item_t            in_data,
  input  cpba_pkg::cpba_cmd_t           cmd,
  output cpba_pkg::cpba_sts_t           sts,
  output cpba_pkg::out_item_t           out_data
);

  localparam int MAP_WORDS = (POOL_PAGES + cpba_pkg::WORD_W - 1) / cpba_pkg::WORD_W;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int PGW       = AW + 5;
  localparam int RW        = $clog2(POOL_PAGES + 1);
  localparam int CW        = cpba_pkg::CNT_W;
  localparam int FW        = cpba_pkg::FIRST_W;
  localparam int ADDR_W    = cpba_pkg::ADDR_W;
  localparam int SIZE_W    = cpba_pkg::SIZE_W;
  localparam int WORD_W    = cpba_pkg::WORD_W;

  localparam logic [AW-1:0] LAST_W  = AW'(MAP_WORDS - 1);
  localparam logic [PGW:0]  POOL_PG = (PGW + 1)'(POOL_PAGES);
  localparam logic [CW-1:0] POOL_C  = CW'(POOL_PAGES);
  localparam logic [FW:0]   POOL_F  = (FW + 1)'(POOL_PAGES);

  // Request and configuration registers
  cpba_pkg::in_item_t            req_r;
  logic [ADDR_W-1:0]             base_r;
  logic [CW-1:0]                 cnt_r;
  logic [FW-1:0]                 first_r;
  logic                          below_r;

  // Scan and mark state
  logic [AW-1:0]                 w_r;
  logic [1:0]                    b_r;
  logic [RW-1:0]                 run_r;
  logic [PGW-1:0]                start_r;
  logic [PGW-1:0]                s_r;
  logic [PGW-1:0]                e_r;

  // Pending result and output register
  logic [cpba_pkg::STAT_W-1:0]   stat_r;
  logic [ADDR_W-1:0]             raddr_r;
  cpba_pkg::out_item_t           out_r;

  // Bitmap RAM ports
  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [WORD_W-1:0]             ram_wdata;
  logic                          ram_re;
  logic [AW-1:0]                 ram_raddr;
  logic [WORD_W-1:0]             ram_rdata;

  // Combinational helpers
  logic [SIZE_W:0]               size_sum;
  logic [ADDR_W:0]               addr_diff;
  logic [FW:0]                   free_end;
  logic                          reject;
  logic [7:0]                    scan_byte;
  logic [RW-1:0]                 run_v;
  logic [PGW-1:0]                start_v;
  logic                          hit_v;
  logic [PGW-1:0]                hit_start;
  logic                          scan_last;
  logic [WORD_W-1:0]             mark_mask;

  cpba_ram #(
    .WIDTH (WORD_W),
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_map_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_en   (ram_re),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  // Round size up to pages and take the offset from the window base
  assign size_sum  = {1'b0, req_r.byte_size} + (SIZE_W + 1)'(cpba_pkg::PAGE_BYTES - 1);
  assign addr_diff = {1'b0, req_r.free_address} - {1'b0, base_r};

  // Check the request against the pool
  assign free_end = (FW + 1)'(first_r) + (FW + 1)'(cnt_r);
  always_comb begin
    if (req_r.func == cpba_pkg::FUNC_FREE) begin
      reject = (cnt_r == '0) || below_r || (free_end > POOL_F);
    end else begin
      reject = (cnt_r == '0) || (cnt_r > POOL_C);
    end
  end

  // Walk one bitmap byte; pages past the pool count as used
  assign scan_byte = ram_rdata[{b_r, 3'b000} +: 8];
  always_comb begin
    logic [PGW-1:0] page_v;
    logic           used_v;
    run_v     = run_r;
    start_v   = start_r;
    hit_v     = 1'b0;
    hit_start = start_r;
    for (int j = 0; j < 8; j++) begin
      page_v = {w_r, b_r, 3'(j)};
      used_v = scan_byte[j] || ({1'b0, page_v} >= POOL_PG);
      if (!hit_v) begin
        if (used_v) begin
          run_v = '0;
        end else begin
          if (run_v == '0) begin
            start_v = page_v;
          end
          run_v = run_v + 1'b1;
          if (run_v == cnt_r[RW-1:0]) begin
            hit_v     = 1'b1;
            hit_start = start_v;
          end
        end
      end
    end
  end
  assign scan_last = (w_r == LAST_W) && (b_r == 2'd3);

  // Bits of the current word that fall inside the run
  always_comb begin
    logic [PGW-1:0] page_v;
    for (int j = 0; j < WORD_W; j++) begin
      page_v       = {w_r, 5'(j)};
      mark_mask[j] = (page_v >= s_r) && (page_v <= e_r);
    end
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = w_r;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = w_r + 1'b1;
    if (cmd.clr_step) begin
      ram_we = 1'b1;
    end
    if (cmd.mark_step) begin
      ram_we    = 1'b1;
      ram_wdata = (req_r.func == cpba_pkg::FUNC_FREE) ? (ram_rdata & ~mark_mask)
                                                      : (ram_rdata | mark_mask);
      ram_re    = (w_r != e_r[PGW-1:5]);
    end
    if (cmd.decide) begin
      ram_re    = 1'b1;
      ram_raddr = '0;
    end
    if (cmd.scan_step && !hit_v && (b_r == 2'd3)) begin
      // Prefetch the next word while the last byte is checked
      ram_re = 1'b1;
    end
    if (cmd.prep) begin
      ram_re    = 1'b1;
      ram_raddr = s_r[PGW-1:5];
    end
  end

  // Control-side counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r <= '0;
      b_r <= '0;
    end else begin
      if (cmd.clr_step || (cmd.mark_step && (w_r != e_r[PGW-1:5]))) begin
        w_r <= w_r + 1'b1;
      end
      if (cmd.decide) begin
        w_r <= '0;
        b_r <= '0;
      end
      if (cmd.scan_step && !hit_v && !scan_last) begin
        b_r <= b_r + 1'b1;
        if (b_r == 2'd3) begin
          w_r <= w_r + 1'b1;
        end
      end
      if (cmd.prep) begin
        w_r <= s_r[PGW-1:5];
      end
    end
  end

  // Window base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= '0;
    end else if (cfg_we) begin
      base_r <= cfg_wdata;
    end
  end

  // Request, checks, scan and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
    end
    if (cmd.calc) begin
      cnt_r   <= size_sum[SIZE_W:cpba_pkg::PAGE_SHIFT];
      below_r <= addr_diff[ADDR_W];
      first_r <= addr_diff[ADDR_W-1:cpba_pkg::PAGE_SHIFT];
    end
    if (cmd.decide) begin
      run_r   <= '0;
      start_r <= '0;
      s_r     <= first_r[PGW-1:0];
      raddr_r <= '0;
      stat_r  <= cpba_pkg::ST_CHECK;
    end
    if (cmd.scan_step) begin
      run_r   <= run_v;
      start_r <= start_v;
      if (hit_v) begin
        s_r <= hit_start;
      end else if (scan_last) begin
        stat_r <= cpba_pkg::ST_NOSPACE;
      end
    end
    if (cmd.prep) begin
      e_r    <= s_r + PGW'(cnt_r) - 1'b1;
      stat_r <= cpba_pkg::ST_DONE;
      if (req_r.func == cpba_pkg::FUNC_ALLOC) begin
        raddr_r <= base_r + (ADDR_W'(s_r) << cpba_pkg::PAGE_SHIFT);
      end
    end
    if (cmd.resp) begin
      out_r.run_address <= raddr_r;
      out_r.status      <= stat_r;
    end
  end

  assign sts.clr_done  = (w_r == LAST_W);
  assign sts.reject    = reject;
  assign sts.is_free   = (req_r.func == cpba_pkg::FUNC_FREE);
  assign sts.found     = hit_v;
  assign sts.scan_last = scan_last;
  assign sts.mark_last = (w_r == e_r[PGW-1:5]);
  assign out_data      = out_r;

endmodule

// ===== rtl/contiguous_page_bitmap_allocator_top.sv =====
`timescale 1ns / 1ps
// Flow: a rejected request goes straight to its result; a free clears the bitmap words
// its run touches; an allocate scans the bitmap byte by byte, then sets the words of the
// run it finds or reports no space.
// Throughput: one item at a time; the byte-per-cycle bitmap scan sets the rate.
// Reset: synchronous; a clearing pass writes ceil(POOL_PAGES/32) bitmap words, one
// per cycle, with in_ready low; window_base resets to zero.
// ----------------------------------------------------------------------------
// contiguous_page_bitmap_allocator_top
// First-fit contiguous page allocator over a bitmap held in RAM.
// ----------------------------------------------------------------------------
module contiguous_page_bitmap_allocator_top #(
  parameter int POOL_PAGES = cpba_pkg::POOL_PAGES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [cpba_pkg::ADDR_W-1:0] cfg_wdata,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  cpba_pkg::in_item_t          in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output cpba_pkg::out_item_t         out_data
);

  cpba_pkg::cpba_cmd_t cmd;
  cpba_pkg::cpba_sts_t sts;

  cpba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cpba_dp #(
    .POOL_PAGES (POOL_PAGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  // One request in flight: ready drops after every input transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a request is in progress");

  // Only a completed allocate carries an address
  a_addr_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status != cpba_pkg::ST_DONE) |-> out_data.run_address == '0)
    else $error("nonzero run address on a failed request");

  // A search hit always goes on to mark the run
  a_hit_marks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.scan_step && sts.found |=> cmd.prep)
    else $error("search hit not followed by run marking");

  // Reset empties the output slot
  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

// ===== verif/tb_contiguous_page_bitmap_allocator_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_contiguous_page_bitmap_allocator_top
// Drives allocate and free requests into the first-fit page allocator and
// checks every result against a cycle-free model of the page bitmap. A short
// directed run covers rejects, exhaustion, unaligned frees and address wrap;
// random traffic then runs under several window bases and idle patterns.
// ----------------------------------------------------------------------------
module tb_contiguous_page_bitmap_allocator_top;
  import cpba_pkg::*;

  localparam int          POOL        = POOL_PAGES_DEF;
  localparam int          POOL_BYTES  = POOL * PAGE_BYTES;
  localparam int unsigned CYCLE_LIMIT = 3_000_000;
  localparam int          SETTLE      = 8;
  localparam int          DRAIN       = 200;
  localparam logic [ADDR_W-1:0] ADDR_ONES = {ADDR_W{1'b1}};

  typedef struct {
    int unsigned       page;
    logic [SIZE_W-1:0] bytes;
  } live_run_t;

  logic                clk;
  logic                rst_n     = 1'b0;
  logic                cfg_we    = 1'b0;
  logic [ADDR_W-1:0]   cfg_wdata = '0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  in_item_t            in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  out_item_t           out_data;

  // Model state: one bit per page plus the window register
  logic [POOL-1:0]     page_map      = '0;
  logic [ADDR_W-1:0]   window_base_q = '0;

  out_item_t           pending_results[$];
  live_run_t           live_runs[$];
  int                  sender_idle_pct    = 0;
  int                  receiver_stall_pct = 0;
  int                  mismatch_count     = 0;
  int unsigned         cycle_count        = 0;

  contiguous_page_bitmap_allocator_top #(
    .POOL_PAGES(POOL)
  ) uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Apply one request to the bitmap and return the result it must produce
  function automatic out_item_t predict_result(input in_item_t req);
    out_item_t   res;
    logic [63:0] pages;
    logic [63:0] first;
    int unsigned p;
    int unsigned run;
    int unsigned start;
    res        = '0;
    res.status = ST_CHECK;
    pages      = (64'(req.byte_size) + PAGE_BYTES - 1) / PAGE_BYTES;
    run        = 0;
    start      = 0;
    if (req.func == FUNC_ALLOC) begin
      if (pages != 0 && pages <= POOL) begin
        res.status = ST_NOSPACE;
        // first fit: lowest run of free pages long enough
        for (p = 0; p < POOL; p++) begin
          if (page_map[p]) begin
            run = 0;
          end else begin
            if (run == 0) start = p;
            run++;
            if (run == pages) break;
          end
        end
        if (run == pages) begin
          for (p = start; p < start + pages; p++) page_map[p] = 1'b1;
          res.status      = ST_DONE;
          res.run_address = window_base_q + ADDR_W'(64'(start) * PAGE_BYTES);
        end
      end
    end else if (pages != 0 && req.free_address >= window_base_q) begin
      first = 64'(req.free_address - window_base_q) / PAGE_BYTES;
      if (first + pages <= POOL) begin
        // no ownership check: clear whatever is there
        for (p = 32'(first); p < first + pages; p++) page_map[p] = 1'b0;
        res.status = ST_DONE;
      end
    end
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] rand_addr();
    return {16'($urandom), $urandom};
  endfunction

  function automatic logic [SIZE_W-1:0] bytes_for_pages(input int unsigned n);
    return SIZE_W'((n - 1) * PAGE_BYTES + $urandom_range(1, PAGE_BYTES));
  endfunction

  // Present one request, hold it until the transfer, then record its result
  task automatic send_request(input logic func, input logic [SIZE_W-1:0] size,
                              input logic [ADDR_W-1:0] addr, output out_item_t want);
    in_item_t req;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    req.func         = func;
    req.byte_size    = size;
    req.free_address = addr;
    in_valid <= 1'b1;
    in_data  <= req;
    do @(posedge clk); while (!in_ready);
    want = predict_result(req);
    pending_results.push_back(want);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_window_base(input logic [ADDR_W-1:0] base);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= base;
    @(posedge clk);
    cfg_we        <= 1'b0;
    window_base_q  = base;
  endtask

  // Check each result transfer and randomize the receiver stall
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing pending: addr %h status %0d",
                                  out_data.run_address, out_data.status));
      end else begin
        want = pending_results.pop_front();
        if (out_data.run_address !== want.run_address)
          report_mismatch($sformatf("run_address %h, want %h",
                                    out_data.run_address, want.run_address));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d",
                                    out_data.status, want.status));
      end
    end
    out_ready <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // Mostly allocate/free pairs on tracked runs, some whole-pool frees, some noise
  task automatic send_random_item();
    int unsigned       kind;
    int unsigned       idx;
    int unsigned       npages;
    logic              func;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
    out_item_t         got;
    live_run_t         run;
    kind = $urandom_range(99);
    if (kind >= 45 && kind < 83 && live_runs.size() == 0) kind = 0;
    if (kind < 45) begin
      idx    = $urandom_range(99);
      npages = (idx < 85) ? $urandom_range(1, 8) :
               (idx < 97) ? $urandom_range(9, 128) : $urandom_range(129, POOL);
      size   = bytes_for_pages(npages);
      send_request(FUNC_ALLOC, size, rand_addr(), got);
      if (got.status == ST_DONE) begin
        addr      = got.run_address - window_base_q;
        run.page  = 32'(addr / PAGE_BYTES);
        run.bytes = size;
        live_runs.push_back(run);
      end
    end else if (kind < 83) begin
      idx = $urandom_range(live_runs.size() - 1);
      run = live_runs[idx];
      live_runs.delete(idx);
      size = ($urandom_range(9) == 0) ? SIZE_W'($urandom_range(1, run.bytes)) : run.bytes;
      addr = window_base_q + ADDR_W'(run.page) * PAGE_BYTES + $urandom_range(PAGE_BYTES - 1);
      send_request(FUNC_FREE, size, addr, got);
    end else if (kind < 85) begin
      addr = window_base_q + $urandom_range(PAGE_BYTES - 1);
      send_request(FUNC_FREE, SIZE_W'(POOL_BYTES - $urandom_range(PAGE_BYTES - 1)), addr, got);
      live_runs.delete();
    end else begin
      func = 1'($urandom_range(1));
      size = $urandom_range(1) ? $urandom : $urandom_range(2 * PAGE_BYTES);
      case ($urandom_range(2))
        0: begin
          addr = rand_addr();
        end
        1: begin
          addr = window_base_q + $urandom_range((POOL + 8) * PAGE_BYTES);
        end
        default: begin
          addr = window_base_q - $urandom_range(1, PAGE_BYTES);
        end
      endcase
      send_request(func, size, addr, got);
    end
  endtask

  task automatic run_traffic_phase(input int count, input int idle, input int stall,
                                   input logic [ADDR_W-1:0] base);
    write_window_base(base);
    sender_idle_pct    = idle;
    receiver_stall_pct = stall;
    repeat (count) send_random_item();
    wait_idle();
  endtask

  // Rejects, exhaustion, unaligned and unused frees at window base zero
  task automatic test_directed_checks();
    out_item_t got;
    send_request(FUNC_ALLOC, 0, rand_addr(), got);
    send_request(FUNC_ALLOC, 1, ADDR_ONES, got);
    send_request(FUNC_ALLOC, PAGE_BYTES, rand_addr(), got);
    send_request(FUNC_ALLOC, PAGE_BYTES + 1, rand_addr(), got);
    send_request(FUNC_ALLOC, POOL_BYTES + 1, rand_addr(), got);
    send_request(FUNC_ALLOC, 32'hFFFF_FFFF, rand_addr(), got);
    send_request(FUNC_ALLOC, POOL_BYTES, rand_addr(), got);
    send_request(FUNC_FREE, 0, 0, got);
    send_request(FUNC_FREE, PAGE_BYTES, 1, got);
    send_request(FUNC_FREE, 1, 2 * PAGE_BYTES - 1, got);
    send_request(FUNC_FREE, 5 * PAGE_BYTES, (POOL - 4) * PAGE_BYTES, got);
    send_request(FUNC_FREE, 4 * PAGE_BYTES, (POOL - 4) * PAGE_BYTES + 7, got);
    send_request(FUNC_FREE, 1, ADDR_ONES, got);
    send_request(FUNC_FREE, 32'hFFFF_FFFF, 0, got);
    send_request(FUNC_ALLOC, 2 * PAGE_BYTES, rand_addr(), got);
    send_request(FUNC_FREE, POOL_BYTES, 0, got);
    send_request(FUNC_ALLOC, POOL_BYTES, rand_addr(), got);
    send_request(FUNC_ALLOC, 1, rand_addr(), got);
    send_request(FUNC_FREE, POOL_BYTES, 0, got);
  endtask

  // Window at the top of the address space: results wrap, low frees are refused
  task automatic test_window_wrap();
    out_item_t got;
    write_window_base(ADDR_ONES - 16 * PAGE_BYTES + 1);
    send_request(FUNC_ALLOC, 20 * PAGE_BYTES, rand_addr(), got);
    send_request(FUNC_ALLOC, 1, rand_addr(), got);
    send_request(FUNC_FREE, 1, 0, got);
    send_request(FUNC_FREE, 1, ADDR_ONES, got);
    send_request(FUNC_FREE, POOL_BYTES, window_base_q, got);
    write_window_base(ADDR_ONES);
    send_request(FUNC_ALLOC, 1, rand_addr(), got);
    send_request(FUNC_ALLOC, PAGE_BYTES, rand_addr(), got);
    send_request(FUNC_FREE, POOL_BYTES, ADDR_ONES, got);
  endtask

  task automatic test_steady_traffic();
    run_traffic_phase(480, 0, 0, rand_addr() & ~ADDR_W'(PAGE_BYTES - 1));
  endtask

  task automatic test_sparse_sender();
    run_traffic_phase(480, 87, 0, rand_addr());
  endtask

  task automatic test_stalled_receiver();
    run_traffic_phase(480, 0, 87, ADDR_ONES - 100 * PAGE_BYTES);
  endtask

  task automatic test_mixed_idling();
    run_traffic_phase(480, 20, 20, '0);
  endtask

  initial begin
    // Hold reset, then let the clearing pass finish behind in_ready
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    test_directed_checks();
    test_window_wrap();
    test_steady_traffic();
    test_sparse_sender();
    test_stalled_receiver();
    test_mixed_idling();

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/cpba_pkg.sv
rtl/cpba_ram.sv
rtl/cpba_ctrl.sv
rtl/cpba_dp.sv
rtl/contiguous_page_bitmap_allocator_top.sv
verif/tb_contiguous_page_bitmap_allocator_top.sv
